>>> design/sgi_pkg.sv
// Shared constants and types for the segment intersection pipeline.
`default_nettype none

package sgi_pkg;

  // Default coordinate width, signed fixed point.
  localparam int COORD_WIDTH_DEF = 16;

  // The point on segment A is worked out in two lanes, one per axis.
  localparam int LANES  = 2;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;

  // Per-item status that travels down the pipeline next to the data.
  typedef struct packed {
    logic hit;    // both parameters lie in [0,1]
    logic degen;  // zero denominator, segments parallel or degenerate
  } flag_t;

endpackage

`default_nettype wire

>>> design/sgi_if.sv
// Valid/ready channel interfaces for segment pairs in and intersection results out.
`default_nettype none

interface sgi_in_if #(
  parameter int CW = sgi_pkg::COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] a_start_x;
  logic signed [CW-1:0] a_start_y;
  logic signed [CW-1:0] a_end_x;
  logic signed [CW-1:0] a_end_y;
  logic signed [CW-1:0] b_start_x;
  logic signed [CW-1:0] b_start_y;
  logic signed [CW-1:0] b_end_x;
  logic signed [CW-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
    output b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
    input  b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface sgi_out_if #(
  parameter int CW = sgi_pkg::COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;

  modport source (
    output valid, hit, cross_x, cross_y,
    input  ready
  );
  modport sink (
    input  valid, hit, cross_x, cross_y,
    output ready
  );
endinterface

`default_nettype wire

>>> design/segment_intersection.sv
// Top level of the 2D segment intersection pipeline.
//
//   Channel   Dir  Handshake      Payload
//   seg_in    in   valid/ready    a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
//   seg_out   out  valid/ready    hit, cross_x, cross_y
//
// One item enters per cycle while seg_in is ready; each result passes through 4 front
// stages, 3 scaling stages, one divider stage per quotient bit (COORD_WIDTH + 1 of
// them) and the output register.
// Reset clears only the valid bits; data registers are not reset.
// Each stage loads when it is empty or its successor moves, so bubbles close up
// under a stall and seg_in stays ready until every stage holds an item.
`default_nettype none

module segment_intersection #(
  parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sgi_in_if.sink    seg_in,
  sgi_out_if.source seg_out
);
  import sgi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int NW = 2 * DW + 1;
  localparam int RW = NW + DW + 1;
  localparam int QW = CW + 1;

  // Front end to scaling.
  logic                 f_valid, f_ready;
  logic        [NW-1:0] f_den;
  logic signed [NW-1:0] f_na;
  logic signed [DW-1:0] f_dir  [LANES];
  logic signed [CW-1:0] f_base [LANES];
  flag_t                f_flag;

  // Scaling to divider.
  logic                 s_valid, s_ready;
  logic        [NW-1:0] s_den;
  logic        [RW-1:0] s_num  [LANES];
  logic                 s_neg  [LANES];
  logic                 s_ovf  [LANES];
  logic signed [CW-1:0] s_base [LANES];
  flag_t                s_flag;

  // Divider to output stage.
  logic                 d_valid, d_ready;
  logic        [QW-1:0] d_quo  [LANES];
  logic                 d_neg  [LANES];
  logic                 d_ovf  [LANES];
  logic signed [CW-1:0] d_base [LANES];
  flag_t                d_flag;

  logic signed [CW-1:0] o_cross [LANES];

  sgi_front #(.CW(CW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seg_in.valid),
    .in_ready  (seg_in.ready),
    .x1        (seg_in.a_start_x),
    .y1        (seg_in.a_start_y),
    .x2        (seg_in.a_end_x),
    .y2        (seg_in.a_end_y),
    .x3        (seg_in.b_start_x),
    .y3        (seg_in.b_start_y),
    .x4        (seg_in.b_end_x),
    .y4        (seg_in.b_end_y),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .den       (f_den),
    .na        (f_na),
    .dir       (f_dir),
    .base      (f_base),
    .flag      (f_flag)
  );

  sgi_scale #(.CW(CW)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .den       (f_den),
    .na        (f_na),
    .dir       (f_dir),
    .base      (f_base),
    .flag      (f_flag),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .den_o     (s_den),
    .num       (s_num),
    .neg       (s_neg),
    .ovf       (s_ovf),
    .base_o    (s_base),
    .flag_o    (s_flag)
  );

  sgi_div #(.CW(CW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .den       (s_den),
    .num       (s_num),
    .neg       (s_neg),
    .ovf       (s_ovf),
    .base      (s_base),
    .flag      (s_flag),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quo_o     (d_quo),
    .neg_o     (d_neg),
    .ovf_o     (d_ovf),
    .base_o    (d_base),
    .flag_o    (d_flag)
  );

  sgi_sat #(.CW(CW)) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .quo       (d_quo),
    .neg       (d_neg),
    .ovf       (d_ovf),
    .base      (d_base),
    .flag      (d_flag),
    .out_valid (seg_out.valid),
    .out_ready (seg_out.ready),
    .hit       (seg_out.hit),
    .cross_pt  (o_cross)
  );

  assign seg_out.cross_x = o_cross[LANE_X];
  assign seg_out.cross_y = o_cross[LANE_Y];

  // The input side only stalls when the whole pipeline is full and the result is held.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !seg_in.ready |-> (seg_out.valid && !seg_out.ready))
    else $error("input stalled while the pipeline still had room");

  // A zero denominator never reports an intersection.
  a_degen_no_hit: assert property (@(posedge clk) disable iff (rst)
    (f_valid && f_flag.degen) |-> !f_flag.hit)
    else $error("hit reported for parallel segments");

  // A hit keeps the point on A, so neither lane may overflow the quotient.
  a_hit_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (d_valid && d_flag.hit) |-> (!d_ovf[LANE_X] && !d_ovf[LANE_Y]))
    else $error("quotient overflow on an intersecting pair");

endmodule

`default_nettype wire

>>> design/sgi_front.sv
// Front end: differences, cross products, denominator and numerators, hit test.
`default_nettype none

module sgi_front #(
  parameter int CW = sgi_pkg::COORD_WIDTH_DEF,
  localparam int DW = CW + 1,
  localparam int PW = 2 * DW,
  localparam int NW = PW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] x1,
  input  logic signed [CW-1:0] y1,
  input  logic signed [CW-1:0] x2,
  input  logic signed [CW-1:0] y2,
  input  logic signed [CW-1:0] x3,
  input  logic signed [CW-1:0] y3,
  input  logic signed [CW-1:0] x4,
  input  logic signed [CW-1:0] y4,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic        [NW-1:0] den,
  output logic signed [NW-1:0] na,
  output logic signed [DW-1:0] dir [sgi_pkg::LANES],
  output logic signed [CW-1:0] base [sgi_pkg::LANES],
  output sgi_pkg::flag_t       flag
);
  import sgi_pkg::*;

  localparam int NS = 4;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  // Stage 1: edge vectors and the offset between the start points.
  logic signed [DW-1:0] dax1, day1, dbx1, dby1, sx1, sy1;
  logic signed [CW-1:0] x1_1, y1_1;
  // Stage 2: the six cross-product terms.
  logic signed [PW-1:0] pd0, pd1, pa0, pa1, pb0, pb1;
  logic signed [DW-1:0] dax2, day2;
  logic signed [CW-1:0] x1_2, y1_2;
  // Stage 3: denominator and both numerators.
  logic signed [NW-1:0] den3, na3, nb3;
  logic signed [DW-1:0] dax3, day3;
  logic signed [CW-1:0] x1_3, y1_3;
  // Stage 4: sign-normalized values and status.
  logic        [NW-1:0] den4;
  logic signed [NW-1:0] na4;
  logic signed [DW-1:0] dax4, day4;
  logic signed [CW-1:0] x1_4, y1_4;
  flag_t                flag4;

  logic                 den_neg;
  logic signed [NW-1:0] den_m, na_m, nb_m;
  logic                 hit_c;

  // A stage takes a new item when it is empty or its successor moves on.
  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dax1 <= {x2[CW-1], x2} - {x1[CW-1], x1};
      day1 <= {y2[CW-1], y2} - {y1[CW-1], y1};
      dbx1 <= {x4[CW-1], x4} - {x3[CW-1], x3};
      dby1 <= {y4[CW-1], y4} - {y3[CW-1], y3};
      sx1  <= {x1[CW-1], x1} - {x3[CW-1], x3};
      sy1  <= {y1[CW-1], y1} - {y3[CW-1], y3};
      x1_1 <= x1;
      y1_1 <= y1;
    end
  end

  // Stage 2 register: one multiplier per term.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pd0  <= dby1 * dax1;
      pd1  <= dbx1 * day1;
      pa0  <= dbx1 * sy1;
      pa1  <= dby1 * sx1;
      pb0  <= dax1 * sy1;
      pb1  <= day1 * sx1;
      dax2 <= dax1;
      day2 <= day1;
      x1_2 <= x1_1;
      y1_2 <= y1_1;
    end
  end

  // Stage 3 register: differences of the products.
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      den3 <= {pd0[PW-1], pd0} - {pd1[PW-1], pd1};
      na3  <= {pa0[PW-1], pa0} - {pa1[PW-1], pa1};
      nb3  <= {pb0[PW-1], pb0} - {pb1[PW-1], pb1};
      dax3 <= dax2;
      day3 <= day2;
      x1_3 <= x1_2;
      y1_3 <= y1_2;
    end
  end

  // Flip all three signs when the denominator is negative, then test both spans.
  always_comb begin
    den_neg = den3[NW-1];
    den_m   = den_neg ? -den3 : den3;
    na_m    = den_neg ? -na3  : na3;
    nb_m    = den_neg ? -nb3  : nb3;
    hit_c   = (den3 != '0) && !na_m[NW-1] && (na_m <= den_m)
              && !nb_m[NW-1] && (nb_m <= den_m);
  end

  // Stage 4 register.
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      den4        <= den_m;
      na4         <= na_m;
      flag4.hit   <= hit_c;
      flag4.degen <= (den3 == '0);
      dax4        <= dax3;
      day4        <= day3;
      x1_4        <= x1_3;
      y1_4        <= y1_3;
    end
  end

  assign out_valid    = v[NS-1];
  assign den          = den4;
  assign na           = na4;
  assign flag         = flag4;
  assign dir[LANE_X]  = dax4;
  assign dir[LANE_Y]  = day4;
  assign base[LANE_X] = x1_4;
  assign base[LANE_Y] = y1_4;

endmodule

`default_nettype wire

>>> design/sgi_scale.sv
// Scales the direction of A by the numerator and prepares rounded dividends.
`default_nettype none

module sgi_scale #(
  parameter int CW = sgi_pkg::COORD_WIDTH_DEF,
  localparam int DW = CW + 1,
  localparam int NW = 2 * DW + 1,
  localparam int MW = NW + DW,
  localparam int RW = MW + 1,
  localparam int QW = CW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic        [NW-1:0] den,
  input  logic signed [NW-1:0] na,
  input  logic signed [DW-1:0] dir [sgi_pkg::LANES],
  input  logic signed [CW-1:0] base [sgi_pkg::LANES],
  input  sgi_pkg::flag_t       flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic        [NW-1:0] den_o,
  output logic        [RW-1:0] num [sgi_pkg::LANES],
  output logic                 neg [sgi_pkg::LANES],
  output logic                 ovf [sgi_pkg::LANES],
  output logic signed [CW-1:0] base_o [sgi_pkg::LANES],
  output sgi_pkg::flag_t       flag_o
);
  import sgi_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  logic signed [MW-1:0] prod1 [LANES];
  logic        [MW-1:0] mag2  [LANES];
  logic                 neg2  [LANES];
  logic        [RW-1:0] num3  [LANES];
  logic                 neg3  [LANES];
  logic                 ovf3  [LANES];
  logic        [NW-1:0] den1, den2, den3;
  logic signed [CW-1:0] b1 [LANES];
  logic signed [CW-1:0] b2 [LANES];
  logic signed [CW-1:0] b3 [LANES];
  flag_t                f1, f2, f3;

  logic        [RW-1:0] nsum [LANES];
  logic        [RW-1:0] dlim;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: numerator times the lane's component of A's direction.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int l = 0; l < LANES; l++) begin
        prod1[l] <= na * dir[l];
        b1[l]    <= base[l];
      end
      den1 <= den;
      f1   <= flag;
    end
  end

  // Stage 2: sign and magnitude.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int l = 0; l < LANES; l++) begin
        neg2[l] <= prod1[l][MW-1];
        mag2[l] <= prod1[l][MW-1] ? -prod1[l] : prod1[l];
        b2[l]   <= b1[l];
      end
      den2 <= den1;
      f2   <= f1;
    end
  end

  // Add half the divisor for round-to-nearest; flag quotients past the lane width.
  always_comb begin
    dlim = RW'(den2) << QW;
    for (int l = 0; l < LANES; l++) begin
      nsum[l] = RW'(mag2[l]) + RW'(den2 >> 1);
    end
  end

  // Stage 3 register.
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int l = 0; l < LANES; l++) begin
        num3[l] <= nsum[l];
        ovf3[l] <= (nsum[l] >= dlim);
        neg3[l] <= neg2[l];
        b3[l]   <= b2[l];
      end
      den3 <= den2;
      f3   <= f2;
    end
  end

  assign out_valid = v[NS-1];
  assign den_o     = den3;
  assign num       = num3;
  assign neg       = neg3;
  assign ovf       = ovf3;
  assign base_o    = b3;
  assign flag_o    = f3;

endmodule

`default_nettype wire

>>> design/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, both lanes side by side.
`default_nettype none

module sgi_div #(
  parameter int CW = sgi_pkg::COORD_WIDTH_DEF,
  localparam int DW = CW + 1,
  localparam int NW = 2 * DW + 1,
  localparam int RW = NW + DW + 1,
  localparam int QW = CW + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic        [NW-1:0] den,
  input  logic        [RW-1:0] num [sgi_pkg::LANES],
  input  logic                 neg [sgi_pkg::LANES],
  input  logic                 ovf [sgi_pkg::LANES],
  input  logic signed [CW-1:0] base [sgi_pkg::LANES],
  input  sgi_pkg::flag_t       flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic        [QW-1:0] quo_o [sgi_pkg::LANES],
  output logic                 neg_o [sgi_pkg::LANES],
  output logic                 ovf_o [sgi_pkg::LANES],
  output logic signed [CW-1:0] base_o [sgi_pkg::LANES],
  output sgi_pkg::flag_t       flag_o
);
  import sgi_pkg::*;

  localparam int NS = QW;

  logic [NS-1:0] v;
  logic [NS:0]   rdy;

  // Per-stage registers. Remainder and divisor are not needed after the last bit.
  logic        [RW-1:0] rem [QW-1][LANES];
  logic        [NW-1:0] dv  [QW-1];
  logic        [QW-1:0] quo [QW][LANES];
  logic                 sg  [QW][LANES];
  logic                 ov  [QW][LANES];
  logic signed [CW-1:0] bs  [QW][LANES];
  flag_t                fl  [QW];

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~v[k] | rdy[k+1];
  end
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;

    logic        [NW-1:0] d_cur;
    logic        [RW-1:0] r_cur [LANES];
    logic        [QW-1:0] q_cur [LANES];
    logic                 s_cur [LANES];
    logic                 o_cur [LANES];
    logic signed [CW-1:0] b_cur [LANES];
    flag_t                f_cur;
    logic        [RW-1:0] t_cur;
    logic                 ge [LANES];

    // Select this stage's operands: the ports for the first bit, else the previous stage.
    if (j == 0) begin : g_head
      always_comb begin
        d_cur = den;
        f_cur = flag;
        for (int l = 0; l < LANES; l++) begin
          r_cur[l] = num[l];
          q_cur[l] = '0;
          s_cur[l] = neg[l];
          o_cur[l] = ovf[l];
          b_cur[l] = base[l];
        end
      end
    end else begin : g_body
      always_comb begin
        d_cur = dv[j-1];
        f_cur = fl[j-1];
        for (int l = 0; l < LANES; l++) begin
          r_cur[l] = rem[j-1][l];
          q_cur[l] = quo[j-1][l];
          s_cur[l] = sg[j-1][l];
          o_cur[l] = ov[j-1][l];
          b_cur[l] = bs[j-1][l];
        end
      end
    end

    // Trial subtraction of the divisor shifted to this bit position.
    always_comb begin
      t_cur = RW'(d_cur) << SH;
      for (int l = 0; l < LANES; l++) begin
        ge[l] = (r_cur[l] >= t_cur);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        fl[j] <= f_cur;
        for (int l = 0; l < LANES; l++) begin
          quo[j][l] <= ge[l] ? (q_cur[l] | (QW'(1) << SH)) : q_cur[l];
          sg[j][l]  <= s_cur[l];
          ov[j][l]  <= o_cur[l];
          bs[j][l]  <= b_cur[l];
        end
      end
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (rdy[j]) begin
          dv[j] <= d_cur;
          for (int l = 0; l < LANES; l++) begin
            rem[j][l] <= ge[l] ? (r_cur[l] - t_cur) : r_cur[l];
          end
        end
      end
    end
  end

  assign out_valid = v[NS-1];
  assign quo_o     = quo[QW-1];
  assign neg_o     = sg[QW-1];
  assign ovf_o     = ov[QW-1];
  assign base_o    = bs[QW-1];
  assign flag_o    = fl[QW-1];

endmodule

`default_nettype wire

>>> design/sgi_sat.sv
// Output stage: applies the offset to A's start point, saturates, holds the result.
`default_nettype none

module sgi_sat #(
  parameter int CW = sgi_pkg::COORD_WIDTH_DEF,
  localparam int QW = CW + 1,
  localparam int SW = CW + 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic        [QW-1:0] quo [sgi_pkg::LANES],
  input  logic                 neg [sgi_pkg::LANES],
  input  logic                 ovf [sgi_pkg::LANES],
  input  logic signed [CW-1:0] base [sgi_pkg::LANES],
  input  sgi_pkg::flag_t       flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic signed [CW-1:0] cross_pt [sgi_pkg::LANES]
);
  import sgi_pkg::*;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic                 v;
  logic                 hit_q;
  logic signed [CW-1:0] cross_q [LANES];
  logic signed [SW-1:0] sum     [LANES];
  logic signed [CW-1:0] cross_c [LANES];

  assign in_ready = ~v | out_ready;

  // Offset the start point; anything past the coordinate range clips to the rail.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (neg[l]) begin
        sum[l] = {{3{base[l][CW-1]}}, base[l]} - {2'b00, quo[l]};
      end else begin
        sum[l] = {{3{base[l][CW-1]}}, base[l]} + {2'b00, quo[l]};
      end
      if (flag.degen) begin
        cross_c[l] = base[l];
      end else if (ovf[l]) begin
        cross_c[l] = neg[l] ? CMIN : CMAX;
      end else if (sum[l][SW-1:CW-1] != {(SW-CW+1){sum[l][SW-1]}}) begin
        cross_c[l] = sum[l][SW-1] ? CMIN : CMAX;
      end else begin
        cross_c[l] = sum[l][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hit_q   <= flag.hit;
      cross_q <= cross_c;
    end
  end

  assign out_valid = v;
  assign hit       = hit_q;
  assign cross_pt  = cross_q;

endmodule

`default_nettype wire

>>> bench/tb_segment_intersection.sv
// Self-checking testbench for the segment intersection pipeline with random flow control.
`default_nettype none

module tb_segment_intersection;
  import sgi_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int PIPE_LATENCY = CW + 9;
  localparam int RANDOM_PAIRS = 1430;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int LONG_HOLD_AFTER = 300;
  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // Shapes of randomly generated segment pairs.
  typedef enum int {
    PAIR_CLUSTER,
    PAIR_UNIFORM,
    PAIR_PARALLEL,
    PAIR_SHARED_END,
    PAIR_EXTREME,
    PAIR_DEGENERATE
  } pair_kind_t;

  typedef struct {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } seg_pair_t;

  // Expected result plus bookkeeping bits that are not compared.
  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
    bit                   parallel;
    bit                   clipped;
  } isect_t;

  logic clk = 1'b0;
  logic rst;

  sgi_in_if  #(.CW(CW)) seg_in_bus ();
  sgi_out_if #(.CW(CW)) seg_out_bus ();

  segment_intersection #(.COORD_WIDTH(CW)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .seg_in  (seg_in_bus),
    .seg_out (seg_out_bus)
  );

  seg_pair_t pending_pairs[$];
  isect_t    expected_isects[$];
  seg_pair_t offered_pair;

  int  mismatches = 0;
  int  pairs_accepted = 0;
  int  results_checked = 0;
  int  hits_predicted = 0;
  int  parallel_predicted = 0;
  int  clipped_predicted = 0;
  int  in_stall_cycles = 0;
  int  in_idle_left = 0;
  int  out_hold_left = 0;
  bit  long_hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Point on A: base + round(num*d/den), ties away from zero, clipped to range.
  function automatic logic signed [CW-1:0] point_on_a(longint base, longint num, longint d,
                                                     longint den, output bit clipped);
    longint prod, mag, quo, pos;
    prod = num * d;
    mag = (prod < 0) ? -prod : prod;
    quo = (mag + den / 2) / den;
    pos = (prod < 0) ? base - quo : base + quo;
    clipped = (pos > COORD_MAX) || (pos < COORD_MIN);
    if (pos > COORD_MAX)
      pos = COORD_MAX;
    else if (pos < COORD_MIN)
      pos = COORD_MIN;
    return CW'(pos);
  endfunction

  // Exact integer intersection test of two segments.
  function automatic isect_t predict_intersection(seg_pair_t p);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint dax, day, dbx, dby, sx, sy, den, na, nb;
    bit clip_x, clip_y;
    isect_t r;
    x1 = p.a_start_x;
    y1 = p.a_start_y;
    x2 = p.a_end_x;
    y2 = p.a_end_y;
    x3 = p.b_start_x;
    y3 = p.b_start_y;
    x4 = p.b_end_x;
    y4 = p.b_end_y;
    dax = x2 - x1;
    day = y2 - y1;
    dbx = x4 - x3;
    dby = y4 - y3;
    sx = x1 - x3;
    sy = y1 - y3;
    den = dby * dax - dbx * day;
    na = dbx * sy - dby * sx;
    nb = dax * sy - day * sx;
    r.parallel = (den == 0);
    r.clipped = 1'b0;
    if (den == 0) begin
      // Parallel or degenerate: no hit, the point is A's start.
      r.hit = 1'b0;
      r.cross_x = p.a_start_x;
      r.cross_y = p.a_start_y;
    end else begin
      if (den < 0) begin
        den = -den;
        na = -na;
        nb = -nb;
      end
      r.hit = (na >= 0) && (na <= den) && (nb >= 0) && (nb <= den);
      r.cross_x = point_on_a(x1, na, dax, den, clip_x);
      r.cross_y = point_on_a(y1, na, day, den, clip_y);
      r.clipped = clip_x || clip_y;
    end
    return r;
  endfunction

  function automatic longint rand_between(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // Boundary values mixed with the odd arbitrary one.
  function automatic longint extreme_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return COORD_MAX - 1;
      6: return COORD_MAX;
      default: return rand_between(COORD_MIN, COORD_MAX);
    endcase
  endfunction

  task automatic add_pair(longint ax0, longint ay0, longint ax1, longint ay1,
                          longint bx0, longint by0, longint bx1, longint by1);
    seg_pair_t p;
    p.a_start_x = CW'(ax0);
    p.a_start_y = CW'(ay0);
    p.a_end_x   = CW'(ax1);
    p.a_end_y   = CW'(ay1);
    p.b_start_x = CW'(bx0);
    p.b_start_y = CW'(by0);
    p.b_end_x   = CW'(bx1);
    p.b_end_y   = CW'(by1);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  // Mostly zero, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random segment pair of the given shape.
  task automatic add_random_pair(pair_kind_t kind);
    longint cx, cy, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, dx, dy, k;
    cx = rand_between(-30000, 30000);
    cy = rand_between(-30000, 30000);
    ax0 = cx + rand_between(-400, 400);
    ay0 = cy + rand_between(-400, 400);
    ax1 = cx + rand_between(-400, 400);
    ay1 = cy + rand_between(-400, 400);
    bx0 = cx + rand_between(-400, 400);
    by0 = cy + rand_between(-400, 400);
    bx1 = cx + rand_between(-400, 400);
    by1 = cy + rand_between(-400, 400);
    case (kind)
      PAIR_UNIFORM: begin
        ax0 = rand_between(COORD_MIN, COORD_MAX);
        ay0 = rand_between(COORD_MIN, COORD_MAX);
        ax1 = rand_between(COORD_MIN, COORD_MAX);
        ay1 = rand_between(COORD_MIN, COORD_MAX);
        bx0 = rand_between(COORD_MIN, COORD_MAX);
        by0 = rand_between(COORD_MIN, COORD_MAX);
        bx1 = rand_between(COORD_MIN, COORD_MAX);
        by1 = rand_between(COORD_MIN, COORD_MAX);
      end
      PAIR_PARALLEL: begin
        // B is a scaled copy of A's direction, sometimes on the same line.
        dx = rand_between(-100, 100);
        dy = rand_between(-100, 100);
        k = rand_between(-3, 3);
        ax1 = ax0 + dx;
        ay1 = ay0 + dy;
        if ($urandom_range(0, 1) == 0) begin
          bx0 = ax0 + rand_between(-2, 2) * dx;
          by0 = ay0 + (bx0 - ax0 == 0 ? 0 : (bx0 - ax0) / (dx == 0 ? 1 : dx) * dy);
          if (dx == 0)
            by0 = ay0 + rand_between(-2, 2) * dy;
        end
        bx1 = bx0 + k * dx;
        by1 = by0 + k * dy;
      end
      PAIR_SHARED_END: begin
        // B touches A at one of its endpoints.
        case ($urandom_range(0, 3))
          0: begin bx0 = ax0; by0 = ay0; end
          1: begin bx0 = ax1; by0 = ay1; end
          2: begin bx1 = ax0; by1 = ay0; end
          default: begin bx1 = ax1; by1 = ay1; end
        endcase
      end
      PAIR_EXTREME: begin
        ax0 = extreme_coord();
        ay0 = extreme_coord();
        ax1 = extreme_coord();
        ay1 = extreme_coord();
        bx0 = extreme_coord();
        by0 = extreme_coord();
        bx1 = extreme_coord();
        by1 = extreme_coord();
      end
      PAIR_DEGENERATE: begin
        // One segment collapses to a point.
        if ($urandom_range(0, 1) == 0) begin
          ax1 = ax0;
          ay1 = ay0;
        end else begin
          bx1 = bx0;
          by1 = by0;
        end
      end
      default: begin
      end
    endcase
    add_pair(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
  endtask

  // Sender: offers pending items with random gaps and records each accepted one.
  always @(posedge clk) begin
    isect_t exp_r;
    if (rst) begin
      seg_in_bus.valid <= 1'b0;
      in_idle_left = 0;
    end else begin
      if (seg_in_bus.valid && seg_in_bus.ready) begin
        exp_r = predict_intersection(offered_pair);
        expected_isects.insert(expected_isects.size(), exp_r);
        pairs_accepted++;
        hits_predicted += exp_r.hit;
        parallel_predicted += exp_r.parallel;
        clipped_predicted += exp_r.clipped;
      end
      if (seg_in_bus.valid && !seg_in_bus.ready) begin
        in_stall_cycles++;
      end else if (in_idle_left > 0) begin
        in_idle_left--;
        seg_in_bus.valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        offered_pair = pending_pairs.pop_front();
        seg_in_bus.a_start_x <= offered_pair.a_start_x;
        seg_in_bus.a_start_y <= offered_pair.a_start_y;
        seg_in_bus.a_end_x   <= offered_pair.a_end_x;
        seg_in_bus.a_end_y   <= offered_pair.a_end_y;
        seg_in_bus.b_start_x <= offered_pair.b_start_x;
        seg_in_bus.b_start_y <= offered_pair.b_start_y;
        seg_in_bus.b_end_x   <= offered_pair.b_end_x;
        seg_in_bus.b_end_y   <= offered_pair.b_end_y;
        seg_in_bus.valid     <= 1'b1;
        // Every fourth stretch of 128 items goes back to back.
        in_idle_left = ((pairs_accepted / 128) % 4 == 3) ? 0 : pick_gap();
      end else begin
        seg_in_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result against the oldest expectation and throttles ready.
  always @(posedge clk) begin
    isect_t exp_r;
    if (rst) begin
      seg_out_bus.ready <= 1'b0;
      out_hold_left = 0;
    end else begin
      if (seg_out_bus.valid && seg_out_bus.ready) begin
        if (expected_isects.size() == 0) begin
          $error("result with no item outstanding: hit %0b, cross_x %0d, cross_y %0d",
                 seg_out_bus.hit, seg_out_bus.cross_x, seg_out_bus.cross_y);
          mismatches++;
        end else begin
          exp_r = expected_isects.pop_front();
          if (seg_out_bus.hit !== exp_r.hit) begin
            $error("hit: expected %0b, actual %0b", exp_r.hit, seg_out_bus.hit);
            mismatches++;
          end
          if (seg_out_bus.cross_x !== exp_r.cross_x) begin
            $error("cross_x: expected %0d, actual %0d", exp_r.cross_x, seg_out_bus.cross_x);
            mismatches++;
          end
          if (seg_out_bus.cross_y !== exp_r.cross_y) begin
            $error("cross_y: expected %0d, actual %0d", exp_r.cross_y, seg_out_bus.cross_y);
            mismatches++;
          end
        end
        results_checked++;
      end
      if (out_hold_left > 0) begin
        out_hold_left--;
        seg_out_bus.ready <= 1'b0;
      end else if (!long_hold_done && results_checked >= LONG_HOLD_AFTER) begin
        // One long back-pressure window so the pipeline fills and stalls its input.
        long_hold_done = 1'b1;
        out_hold_left = LONG_HOLD_CYCLES;
        seg_out_bus.ready <= 1'b0;
      end else if ((results_checked / 128) % 4 == 1) begin
        seg_out_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 20) begin
        out_hold_left = pick_gap();
        seg_out_bus.ready <= 1'b0;
      end else begin
        seg_out_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind_sel;
    pair_kind_t kind;
    rst = 1'b1;
    seg_in_bus.valid = 1'b0;
    seg_in_bus.a_start_x = '0;
    seg_in_bus.a_start_y = '0;
    seg_in_bus.a_end_x = '0;
    seg_in_bus.a_end_y = '0;
    seg_in_bus.b_start_x = '0;
    seg_in_bus.b_start_y = '0;
    seg_in_bus.b_end_x = '0;
    seg_in_bus.b_end_y = '0;
    seg_out_bus.ready = 1'b0;

    // Directed pairs: field extremes, crossings, touching ends, ties and clipping.
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
             COORD_MAX);
    add_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
             COORD_MIN);
    add_pair(-160, -160, 160, 160, -160, 160, 160, -160);
    add_pair(160, 160, -160, -160, -160, 160, 160, -160);
    add_pair(0, 0, 16, 16, 100, 0, 0, 100);
    add_pair(0, 0, 32, 16, 0, 16, 32, 32);
    add_pair(0, 0, 32, 32, 16, 16, 48, 48);
    add_pair(0, 0, 32, 0, 0, -16, 0, 16);
    add_pair(0, 0, 32, 0, 32, -16, 32, 16);
    add_pair(0, 0, 32, 0, 16, 0, 16, 32);
    add_pair(0, 0, 32, 0, 16, 32, 16, 0);
    add_pair(0, 0, 32, 0, 16, 1, 16, 32);
    add_pair(0, 0, 1, 0, 0, -1, 1, 1);
    add_pair(0, 0, -1, 0, 0, -1, -1, 1);
    add_pair(0, 0, 2, 1, 0, COORD_MAX, 1, COORD_MAX);
    add_pair(0, 0, -2, -1, 0, COORD_MIN, 1, COORD_MIN);
    add_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
             COORD_MIN);
    add_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
             COORD_MAX);
    add_pair(5, 5, 5, 5, 0, 0, 10, 10);
    add_pair(0, 0, 10, 10, 5, 5, 5, 5);
    add_pair(-7, 3, 9, -2, 1, -20, 2, 20);

    // Random pairs, weighted toward shapes that reach hits and edge cases.
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      kind_sel = $urandom_range(0, 99);
      if (kind_sel < 35)
        kind = PAIR_CLUSTER;
      else if (kind_sel < 60)
        kind = PAIR_UNIFORM;
      else if (kind_sel < 70)
        kind = PAIR_PARALLEL;
      else if (kind_sel < 80)
        kind = PAIR_SHARED_END;
      else if (kind_sel < 90)
        kind = PAIR_EXTREME;
      else
        kind = PAIR_DEGENERATE;
      add_random_pair(kind);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Drain: all items accepted, all results back, then a quiet window.
    while (pending_pairs.size() != 0 || seg_in_bus.valid || expected_isects.size() != 0)
      @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Checked %0d results for %0d segment pairs: %0d hits, %0d parallel, %0d clipped.",
             results_checked, pairs_accepted, hits_predicted, parallel_predicted,
             clipped_predicted);
    $display("Input held off by output back-pressure for %0d cycles.", in_stall_cycles);
    if (mismatches == 0 && expected_isects.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog for a hung pipeline.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
design/sgi_pkg.sv
design/sgi_if.sv
design/sgi_front.sv
design/sgi_scale.sv
design/sgi_div.sv
design/sgi_sat.sv
design/segment_intersection.sv
bench/tb_segment_intersection.sv
